[hdl/encoder_turn_controller_defines.svh]
// assertion macros used by the encoder turn controller
`ifndef ENCODER_TURN_CONTROLLER_DEFINES_SVH
`define ENCODER_TURN_CONTROLLER_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define ETC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define ETC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/etc_pkg.sv]
// shared types, constants and helper functions of the encoder turn controller
package etc_pkg;

  localparam int TGT_W  = 24;
  localparam int QUO_W  = 16;
  localparam int FRAC_SH = 12;
  localparam int NUM_W  = 43 + FRAC_SH;
  localparam int CFG_IDX_W = 3;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_START_LEFT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_RIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_LEFT   = 3'd4;

  localparam logic [TGT_W-1:0] TARGET_RESET = 24'd256;
  localparam logic [6:0] SPEED_FINISH = 7'd65;

  // dead-band limits in q12
  localparam logic signed [24:0] DB_NEG_LIMIT = -25'sd12288;
  localparam logic signed [24:0] DB_POS_LIMIT = 25'sd8192;
  localparam logic signed [24:0] DB_NEG_SMALL = -25'sd8192;
  localparam logic signed [24:0] Q12_ONE      = 25'sd4096;
  localparam logic signed [7:0]  DRIVE_CORR   = 8'sd3;

  typedef struct packed {
    logic load;
    logic step;
  } etc_div_ctrl_t;

  // stop band in unsigned q0.12, picked from the turn speed
  function automatic logic [11:0] etc_stop_band(input logic [6:0] speed);
    logic [11:0] band;
    if (speed < 7'd21) begin
      band = 12'd410;
    end else if (speed < 7'd42) begin
      band = 12'd819;
    end else if (speed < 7'd75) begin
      band = 12'd1229;
    end else if (speed < 7'd100) begin
      band = 12'd1638;
    end else begin
      band = 12'd2048;
    end
    return band;
  endfunction

  // q12 value to integer, rounded toward zero
  function automatic logic [7:0] etc_trunc_q12(input logic signed [24:0] v);
    logic signed [24:0] b;
    b = v + (v[24] ? 25'sd4095 : 25'sd0);
    return b[19:12];
  endfunction

endpackage

[hdl/etc_div.sv]
// iterative restoring divider, one quotient bit per step, saturation bit on top
module etc_div (
  input  logic                      clk_i,
  input  etc_pkg::etc_div_ctrl_t    ctrl_i,
  input  logic [etc_pkg::NUM_W-1:0] num_i,
  input  logic [etc_pkg::TGT_W-1:0] den_i,
  output logic [etc_pkg::QUO_W-1:0] quo_o
);
  import etc_pkg::*;

  localparam int DSR_W = TGT_W + QUO_W - 1;

  logic [NUM_W-1:0] rem_q, rem_d;
  logic [DSR_W-1:0] dsr_q, dsr_d;
  logic [QUO_W-1:0] quo_q, quo_d;
  logic [NUM_W:0]   diff;
  logic             ge;

  // shared trial subtract
  assign diff = {1'b0, rem_q} - {{(NUM_W + 1 - DSR_W){1'b0}}, dsr_q};
  assign ge   = !diff[NUM_W];

  always_comb begin
    rem_d = rem_q;
    dsr_d = dsr_q;
    quo_d = quo_q;
    if (ctrl_i.load) begin
      rem_d = num_i;
      dsr_d = {den_i, {(QUO_W - 1){1'b0}}};
      quo_d = '0;
    end else if (ctrl_i.step) begin
      if (ge) begin
        rem_d = diff[NUM_W-1:0];
      end
      dsr_d = {1'b0, dsr_q[DSR_W-1:1]};
      quo_d = {quo_q[QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign quo_o = quo_q;

endmodule

[hdl/encoder_turn_controller.sv]
// encoder turn controller: sequencer, datapath and output register
//
// usage: write start_left, start_right, target_ticks_q8, turn_speed and
// turn_left on the cfg channel (index 0..4, other indexes ignored) while the
// block is idle, then stream encoder samples on s_axis (left count in
// tdata[31:0], right count in tdata[63:32]). every request gives one result on
// m_axis: tdata holds left_drive [7:0] and right_drive [15:8], tuser holds
// drive_valid [0] and finished [1].
// the request is taken, passes the setup states, the 16-step divider, run once
// for each wheel, and the multiply and sign states, then lands in the output
// register; s_axis_tready rises in the same cycle, so a new sample is only taken
// once the last one has reached the output register. once the turn has finished,
// a sample goes straight to the output stage and only reports finished.
// reset clears the config and state registers to their defaults (target one
// tick) and starts a new turn. if the receiver stalls, the result is held in the
// output register while the next sample is accepted and worked on; that one then
// waits in its last stage until the output register frees up.
`include "encoder_turn_controller_defines.svh"

module encoder_turn_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  // cfg write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [etc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // sample input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // left_count [31:0], right_count [63:32]
  // drive output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // left_drive [7:0], right_drive [15:8]
  output logic [1:0]  m_axis_tuser    // drive_valid [0], finished [1]
);
  import etc_pkg::*;

  // sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_ABS  = 4'd1;
  localparam logic [3:0] ST_SUM  = 4'd2;
  localparam logic [3:0] ST_NUM  = 4'd3;
  localparam logic [3:0] ST_LOAD = 4'd4;
  localparam logic [3:0] ST_DIV  = 4'd5;
  localparam logic [3:0] ST_FRAC = 4'd6;
  localparam logic [3:0] ST_MUL  = 4'd7;
  localparam logic [3:0] ST_SGN  = 4'd8;
  localparam logic [3:0] ST_OUT  = 4'd9;

  // configuration
  logic [31:0]      start_l_q, start_r_q;
  logic [TGT_W-1:0] tgt_q;
  logic [6:0]       speed_q;
  logic             tleft_q;

  // turn state
  logic [31:0] last_l_q, last_r_q;
  logic        corr_q, corr_d;
  logic        done_q, done_d;

  // sequencer
  logic [3:0] state_q;
  logic [3:0] cnt_q;
  logic       wheel_q;
  logic       skip_q;

  // working registers
  logic signed [32:0] dist_l_q, dist_r_q;
  logic signed [32:0] delta_l_q, delta_r_q;
  logic signed [34:0] x_l_q, x_r_q;
  logic signed [43:0] d_l_q, d_r_q;
  logic               hit_q;
  logic               neg_q;
  logic signed [15:0] frac_l_q, frac_r_q;
  logic               fwd_q, rev_q;
  logic signed [23:0] prod_l_q, prod_r_q;
  logic signed [24:0] sl_q, sr_q;

  // output register
  logic        m_valid_q;
  logic [15:0] m_data_q;
  logic [1:0]  m_user_q;

  logic             s_fire;
  logic             out_load;
  logic [TGT_W-1:0] tq8;
  logic [15:0]      tgt_int;
  logic [31:0]      in_l, in_r;

  // divider hookup
  etc_div_ctrl_t      div_ctrl;
  logic signed [43:0] d_cur;
  logic signed [43:0] d_mag;
  logic [NUM_W-1:0]   div_num;
  logic [QUO_W-1:0]   div_quo;
  logic signed [15:0] frac_pos;
  logic signed [15:0] frac_new;

  // stop band compare
  logic [11:0]        stop;
  logic signed [15:0] stop_s;

  // sign stage
  logic signed [24:0] v_l, v_r;

  // result decision
  logic [7:0] spd8, nspd8;
  logic       prop, c1, c2, corr_new;
  logic [7:0] res_l, res_r;
  logic       res_drv, res_fin;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign in_l          = s_axis_tdata[31:0];
  assign in_r          = s_axis_tdata[63:32];

  // a zero target acts as one
  assign tq8     = (tgt_q == '0) ? {{(TGT_W - 1){1'b0}}, 1'b1} : tgt_q;
  assign tgt_int = tq8[TGT_W-1:8];

  // divider: numerator is |target - 256 * x| scaled to q12
  assign div_ctrl.load = (state_q == ST_LOAD);
  assign div_ctrl.step = (state_q == ST_DIV);
  assign d_cur   = wheel_q ? d_r_q : d_l_q;
  assign d_mag   = d_cur[43] ? -d_cur : d_cur;
  assign div_num = {d_mag[42:0], {FRAC_SH{1'b0}}};

  etc_div u_div (
    .clk_i  (clk_i),
    .ctrl_i (div_ctrl),
    .num_i  (div_num),
    .den_i  (tq8),
    .quo_o  (div_quo)
  );

  // top quotient bit means the fraction is out of q3.12 range
  assign frac_pos = $signed({1'b0, div_quo[QUO_W-2:0]});
  always_comb begin
    if (div_quo[QUO_W-1]) begin
      frac_new = neg_q ? -16'sd32768 : 16'sd32767;
    end else begin
      frac_new = neg_q ? -frac_pos : frac_pos;
    end
  end

  assign stop   = etc_stop_band(speed_q);
  assign stop_s = $signed({4'b0, stop});

  assign v_l = $signed({prod_l_q[23], prod_l_q}) + Q12_ONE;
  assign v_r = $signed({prod_r_q[23], prod_r_q}) + Q12_ONE;

  // final decision: direction, dead-band correction and finish rules
  always_comb begin
    spd8     = {1'b0, speed_q};
    nspd8    = 8'd0 - spd8;
    prop     = !fwd_q && !rev_q;
    c1       = (sl_q > DB_NEG_LIMIT && sl_q < 25'sd0) ||
               (sr_q > 25'sd0 && sr_q < DB_POS_LIMIT);
    c2       = (sl_q > 25'sd0 && sl_q < DB_POS_LIMIT) ||
               (sr_q < 25'sd0 && sr_q > DB_NEG_SMALL);
    corr_new = corr_q || (prop && c1);
    res_l    = '0;
    res_r    = '0;
    res_drv  = 1'b0;
    res_fin  = 1'b0;
    corr_d   = corr_q;
    done_d   = done_q;
    if (skip_q) begin
      res_fin = 1'b1;
    end else if (hit_q) begin
      // target reached: finish or hold still
      corr_d = corr_new;
      if (speed_q > SPEED_FINISH && corr_new) begin
        corr_d  = 1'b0;
        done_d  = 1'b1;
        res_fin = 1'b1;
      end else if (speed_q < SPEED_FINISH) begin
        done_d  = 1'b1;
        res_fin = 1'b1;
      end
    end else begin
      corr_d  = corr_new;
      res_drv = 1'b1;
      if (fwd_q) begin
        res_l = tleft_q ? nspd8 : spd8;
        res_r = tleft_q ? spd8 : nspd8;
      end else if (rev_q) begin
        res_l = tleft_q ? spd8 : nspd8;
        res_r = tleft_q ? nspd8 : spd8;
      end else if (c1 || c2) begin
        res_l = tleft_q ? DRIVE_CORR : -DRIVE_CORR;
        res_r = tleft_q ? -DRIVE_CORR : DRIVE_CORR;
      end else begin
        res_l = etc_trunc_q12(sl_q);
        res_r = etc_trunc_q12(sr_q);
      end
    end
  end

  assign out_load = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_l_q <= '0;
      start_r_q <= '0;
      tgt_q     <= TARGET_RESET;
      speed_q   <= '0;
      tleft_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_START_LEFT:  start_l_q <= cfg_data_i;
        REG_START_RIGHT: start_r_q <= cfg_data_i;
        REG_TARGET:      tgt_q     <= cfg_data_i[TGT_W-1:0];
        REG_SPEED:       speed_q   <= cfg_data_i[6:0];
        REG_TURN_LEFT:   tleft_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // sequencer and turn state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      wheel_q   <= 1'b0;
      skip_q    <= 1'b0;
      last_l_q  <= '0;
      last_r_q  <= '0;
      corr_q    <= 1'b0;
      done_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      // a new result may replace the one leaving in the same cycle
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_fire) begin
            skip_q <= done_q;
            if (done_q) begin
              state_q <= ST_OUT;
            end else begin
              last_l_q <= in_l;
              last_r_q <= in_r;
              state_q  <= ST_ABS;
            end
          end
        end
        ST_ABS:  state_q <= ST_SUM;
        ST_SUM:  state_q <= ST_NUM;
        ST_NUM: begin
          wheel_q <= 1'b0;
          state_q <= ST_LOAD;
        end
        ST_LOAD: begin
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'(QUO_W - 1)) begin
            state_q <= ST_FRAC;
          end
        end
        ST_FRAC: begin
          if (wheel_q) begin
            state_q <= ST_MUL;
          end else begin
            wheel_q <= 1'b1;
            state_q <= ST_LOAD;
          end
        end
        ST_MUL:  state_q <= ST_SGN;
        ST_SGN:  state_q <= ST_OUT;
        ST_OUT: begin
          if (out_load) begin
            corr_q  <= corr_d;
            done_q  <= done_d;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        dist_l_q  <= $signed({in_l[31], in_l}) - $signed({start_l_q[31], start_l_q});
        dist_r_q  <= $signed({in_r[31], in_r}) - $signed({start_r_q[31], start_r_q});
        delta_l_q <= $signed({in_l[31], in_l}) - $signed({last_l_q[31], last_l_q});
        delta_r_q <= $signed({in_r[31], in_r}) - $signed({last_r_q[31], last_r_q});
      end
      ST_ABS: begin
        dist_l_q <= dist_l_q[32] ? -dist_l_q : dist_l_q;
        dist_r_q <= dist_r_q[32] ? -dist_r_q : dist_r_q;
      end
      ST_SUM: begin
        x_l_q <= $signed({{2{dist_l_q[32]}}, dist_l_q}) +
                 $signed({{2{delta_l_q[32]}}, delta_l_q});
        x_r_q <= $signed({{2{dist_r_q[32]}}, dist_r_q}) +
                 $signed({{2{delta_r_q[32]}}, delta_r_q});
        hit_q <= (dist_l_q == $signed({17'b0, tgt_int})) ||
                 (dist_r_q == $signed({17'b0, tgt_int}));
      end
      ST_NUM: begin
        d_l_q <= $signed({20'b0, tq8}) - $signed({x_l_q[34], x_l_q, 8'b0});
        d_r_q <= $signed({20'b0, tq8}) - $signed({x_r_q[34], x_r_q, 8'b0});
      end
      ST_LOAD: begin
        neg_q <= d_cur[43];
      end
      ST_FRAC: begin
        if (wheel_q) begin
          frac_r_q <= frac_new;
        end else begin
          frac_l_q <= frac_new;
        end
      end
      ST_MUL: begin
        fwd_q    <= (frac_l_q > stop_s) || (frac_r_q > stop_s);
        rev_q    <= (frac_l_q < -stop_s) || (frac_r_q < -stop_s);
        prod_l_q <= frac_l_q * $signed({1'b0, speed_q});
        prod_r_q <= frac_r_q * $signed({1'b0, speed_q});
      end
      ST_SGN: begin
        // left wheel runs backward on a left turn, right wheel forward
        sl_q <= tleft_q ? -v_l : v_l;
        sr_q <= tleft_q ? v_r : -v_r;
      end
      default: ;
    endcase
    if (out_load) begin
      m_data_q <= {res_r, res_l};
      m_user_q <= {res_fin, res_drv};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  `ETC_ASSERT_NXT(a_busy_after_accept, s_fire, !s_axis_tready, "accepted while busy")
  `ETC_ASSERT_NXT(a_done_sticky, done_q, done_q, "finished turn restarted")
  `ETC_ASSERT_IMP(a_drive_or_finish, m_axis_tvalid && m_axis_tuser[0], !m_axis_tuser[1], "drive and finish together")
  `ETC_ASSERT_IMP(a_drive_range, m_axis_tvalid && m_axis_tuser[0], (m_axis_tdata[7:0] != 8'h80) && (m_axis_tdata[15:8] != 8'h80), "drive out of range")

endmodule
